@@ rtl/sprd_pkg.sv @@
// Shared codes, field widths and word types for the sprite skip-run decoder.
// No dependencies; every rtl file refers to this package by scoped names.
`timescale 1ns / 1ps

package sprd_pkg;

    // Control bytes of the compressed stream
    localparam logic [7:0] CODE_SKIP  = 8'hFE;
    localparam logic [7:0] CODE_END   = 8'hFF;
    localparam logic [7:0] CODE_CLEAR = 8'h00;

    // Field widths of the stream words
    localparam int CODE_W   = 8;
    localparam int PIX_X_W  = 5;
    localparam int PIX_Y_W  = 6;
    localparam int OUT_DATA_W = 24;

    // Skip byte split into whole rows and leftover columns.
    // Canvas width is at least 8, so rows fit in 5 bits; columns are below 64.
    localparam int SKIP_ROWS_W = 5;
    localparam int SKIP_COLS_W = 6;

    // Row sum before saturation: height (<= 64) + skip rows (<= 31) + carry
    localparam int ROW_SUM_W = 8;

    // Fixed-point reciprocal precision for splitting the skip byte
    localparam int RECIP_FRAC_W = 16;

    // One registered input word with its precomputed skip split
    typedef struct packed {
        logic [CODE_W-1:0]      code;
        logic                   last;
        logic [SKIP_ROWS_W-1:0] skip_rows;
        logic [SKIP_COLS_W-1:0] skip_cols;
    } item_t;

endpackage

@@ rtl/sprd_in_stage.sv @@
// Input register of the sprite skip-run decoder: captures each stream word
// and splits the byte into canvas rows and columns. Depends on sprd_pkg.
`timescale 1ns / 1ps

module sprd_in_stage #(
    parameter int CANVAS_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [sprd_pkg::CODE_W-1:0] s_tdata,    // [7:0] code_byte
    input  logic                        s_tlast,    // final_byte
    input  logic                        take,
    output logic                        item_valid,
    output sprd_pkg::item_t             item
);

    // Rounded-up reciprocal; exact quotient for every byte value when width <= 64
    localparam int RECIP   = ((1 << sprd_pkg::RECIP_FRAC_W) + CANVAS_WIDTH - 1) / CANVAS_WIDTH;
    localparam int RECIP_W = sprd_pkg::RECIP_FRAC_W + 1;
    localparam int PROD_W  = sprd_pkg::CODE_W + RECIP_W;

    logic                    valid_reg;
    logic                    valid_next;
    sprd_pkg::item_t         item_reg;
    sprd_pkg::item_t         item_next;
    logic                    s_acc;
    logic [PROD_W-1:0]       recip_prod;
    logic [sprd_pkg::SKIP_ROWS_W-1:0] rows;
    logic [sprd_pkg::CODE_W:0]        rows_times_w;
    logic [sprd_pkg::CODE_W:0]        cols_full;

    // Accept a word whenever the register is empty or drains this cycle
    assign s_tready = !valid_reg || take;
    assign s_acc    = s_tvalid && s_tready;

    // Split the byte: rows = byte / width, cols = byte - rows * width
    always_comb begin
        recip_prod   = PROD_W'(s_tdata) * PROD_W'(RECIP);
        rows         = sprd_pkg::SKIP_ROWS_W'(recip_prod >> sprd_pkg::RECIP_FRAC_W);
        rows_times_w = (sprd_pkg::CODE_W+1)'(rows) * (sprd_pkg::CODE_W+1)'(CANVAS_WIDTH);
        cols_full    = (sprd_pkg::CODE_W+1)'(s_tdata) - rows_times_w;
    end

    always_comb begin
        item_next           = item_reg;
        item_next.code      = s_tdata;
        item_next.last      = s_tlast;
        item_next.skip_rows = rows;
        item_next.skip_cols = sprd_pkg::SKIP_COLS_W'(cols_full);
        valid_next          = valid_reg;
        if (s_acc) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    // Clear valid under reset; payload loads on accept only
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ rtl/sprd_core.sv @@
// Frame state and result register of the sprite skip-run decoder: tracks the
// write column and row, forms pixel and terminator words. Depends on sprd_pkg.
`timescale 1ns / 1ps

module sprd_core #(
    parameter int CANVAS_WIDTH  = 32,
    parameter int CANVAS_HEIGHT = 48
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            item_valid,
    input  sprd_pkg::item_t                 item,
    output logic                            take,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sprd_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                            m_tlast,
    output logic [0:0]                      m_tuser
);

    localparam int XW = $clog2(CANVAS_WIDTH);
    localparam int YW = $clog2(CANVAS_HEIGHT + 1);

    // Frame state; row == height (column 0) is the saturated end of canvas
    logic          hdr_reg, hdr_next;
    logic          skip_reg, skip_next;
    logic [XW-1:0] col_reg, col_next;
    logic [YW-1:0] row_reg, row_next;

    // Result register
    logic                            out_valid_reg, out_valid_next;
    logic [sprd_pkg::OUT_DATA_W-1:0] data_reg, data_next;
    logic                            done_reg, done_next;
    logic                            bad_reg, bad_next;

    logic                       emit;
    logic                       is_pixel;
    logic                       at_end;
    logic [XW:0]                col_inc;
    logic [XW:0]                col_sum;
    logic [XW:0]                col_fix;
    logic                       col_carry;
    logic [sprd_pkg::ROW_SUM_W-1:0] row_sum;

    // Advance the word when the result slot is free or drains this cycle
    assign take   = item_valid && (!out_valid_reg || m_tready);
    assign at_end = (row_reg == YW'(CANVAS_HEIGHT));

    // Column arithmetic for advances and skips
    always_comb begin
        col_inc   = {1'b0, col_reg} + (XW+1)'(1);
        col_sum   = {1'b0, col_reg} + (XW+1)'(item.skip_cols);
        col_carry = (col_sum >= (XW+1)'(CANVAS_WIDTH));
        col_fix   = col_carry ? (col_sum - (XW+1)'(CANVAS_WIDTH)) : col_sum;
        row_sum   = sprd_pkg::ROW_SUM_W'(row_reg) + sprd_pkg::ROW_SUM_W'(item.skip_rows)
                  + sprd_pkg::ROW_SUM_W'(col_carry);
    end

    // Decode the byte and step the frame state
    always_comb begin
        hdr_next  = hdr_reg;
        skip_next = skip_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        is_pixel  = 1'b0;
        emit      = 1'b0;

        if (item.last) begin
            hdr_next  = 1'b1;
            skip_next = 1'b0;
            col_next  = '0;
            row_next  = '0;
            emit      = 1'b1;
        end else if (hdr_reg) begin
            hdr_next = 1'b0;
            col_next = '0;
            if (item.code >= sprd_pkg::CODE_W'(CANVAS_HEIGHT)) begin
                row_next = YW'(CANVAS_HEIGHT);
            end else begin
                row_next = YW'(item.code);
            end
        end else if (skip_reg) begin
            skip_next = 1'b0;
            if (row_sum >= sprd_pkg::ROW_SUM_W'(CANVAS_HEIGHT)) begin
                row_next = YW'(CANVAS_HEIGHT);
                col_next = '0;
            end else begin
                row_next = YW'(row_sum);
                col_next = XW'(col_fix);
            end
        end else if (item.code == sprd_pkg::CODE_SKIP) begin
            skip_next = 1'b1;
        end else begin
            // Transparent and pixel bytes both advance one place
            if (item.code != sprd_pkg::CODE_CLEAR) begin
                is_pixel = !at_end;
                emit     = !at_end;
            end
            if (!at_end) begin
                if (col_inc == (XW+1)'(CANVAS_WIDTH)) begin
                    col_next = '0;
                    row_next = row_reg + YW'(1);
                end else begin
                    col_next = XW'(col_inc);
                end
            end
        end
    end

    // Form the result word; clipped pixels never reach here
    always_comb begin
        data_next = data_reg;
        done_next = done_reg;
        bad_next  = bad_reg;
        if (is_pixel) begin
            data_next = {5'b0, item.code,
                         sprd_pkg::PIX_Y_W'(row_reg), sprd_pkg::PIX_X_W'(col_reg)};
            done_next = 1'b0;
            bad_next  = 1'b0;
        end else begin
            data_next = '0;
            done_next = 1'b1;
            bad_next  = (item.code != sprd_pkg::CODE_END);
        end

        out_valid_next = out_valid_reg;
        if (take && emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg       <= 1'b1;
            skip_reg      <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take) begin
                hdr_reg  <= hdr_next;
                skip_reg <= skip_next;
                col_reg  <= col_next;
                row_reg  <= row_next;
            end
        end
    end

    // Load payload only with a new result
    always_ff @(posedge aclk) begin
        if (take && emit) begin
            data_reg <= data_next;
            done_reg <= done_next;
            bad_reg  <= bad_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = done_reg;
    assign m_tuser  = bad_reg;

endmodule

@@ rtl/sprite_skip_run_decoder.sv @@
// Top level of the sprite skip-run decoder: input register plus decode core.
// Depends on sprd_pkg, sprd_in_stage and sprd_core.
//
//   channel   direction  tdata                                   tlast        tuser
//   s_        in         [7:0] code_byte                         final_byte   -
//   m_        out        [4:0] pixel_x [10:5] pixel_y            frame_done   bad_terminator
//                        [18:11] palette_index, [23:19] zero
//
// One byte per cycle while the output is not stalled; an accepted byte passes
// the input register, then the result register, on its way to its result.
// Transparent, skip, header and clipped bytes give no output word.
// Reset (aresetn low, synchronous) empties both registers and expects a header.
// An output stall holds the result word and lets one more byte into the input
// register; s_tready follows m_tready within the same cycle after that.
`timescale 1ns / 1ps

module sprite_skip_run_decoder #(
    parameter int CANVAS_WIDTH  = 32,
    parameter int CANVAS_HEIGHT = 48
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sprd_pkg::CODE_W-1:0]     s_tdata,   // [7:0] code_byte
    input  logic                            s_tlast,   // final_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sprd_pkg::OUT_DATA_W-1:0] m_tdata,   // [4:0] pixel_x, [10:5] pixel_y,
                                                       // [18:11] palette_index, rest 0
    output logic                            m_tlast,   // frame_done
    output logic [0:0]                      m_tuser    // [0] bad_terminator
);

    logic            item_valid;
    logic            take;
    sprd_pkg::item_t item;

    // Capture words and split skip bytes
    sprd_in_stage #(
        .CANVAS_WIDTH (CANVAS_WIDTH)
    ) u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // Decode and drive results
    sprd_core #(
        .CANVAS_WIDTH  (CANVAS_WIDTH),
        .CANVAS_HEIGHT (CANVAS_HEIGHT)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

@@ rtl/sprd_checker.sv @@
// Port-level checks for the sprite skip-run decoder, bound to the top level.
// Depends on sprd_pkg for port widths.
`timescale 1ns / 1ps

module sprd_checker #(
    parameter int CANVAS_WIDTH  = 32,
    parameter int CANVAS_HEIGHT = 48
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [sprd_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tlast,
    input logic [0:0]                      m_tuser
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                 && $stable(m_tuser))
        else $error("stalled result changed");

    // Terminator words carry no pixel
    a_done_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == '0)
        else $error("terminator word carries pixel data");

    // Pixel words never flag a bad terminator
    a_pixel_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser == 1'b0)
        else $error("pixel word flagged as bad terminator");

    // Pixels stay on the canvas (checked for width <= 32 and height <= 64)
    a_on_canvas: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast && CANVAS_WIDTH <= 32 && CANVAS_HEIGHT <= 64
        |-> (7'(m_tdata[4:0]) < 7'(CANVAS_WIDTH)) && (7'(m_tdata[10:5]) < 7'(CANVAS_HEIGHT)))
        else $error("pixel outside canvas");

endmodule

bind sprite_skip_run_decoder sprd_checker #(
    .CANVAS_WIDTH  (CANVAS_WIDTH),
    .CANVAS_HEIGHT (CANVAS_HEIGHT)
) u_sprd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

@@ tb/tb.sv @@
// Self-checking testbench for sprite_skip_run_decoder: directed frames, random
// frames and raw byte noise, with random idling on both stream channels.
// Depends on sprd_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module tb;

    localparam int CANVAS_W     = 32;
    localparam int CANVAS_H     = 48;
    localparam int CANVAS_CELLS = CANVAS_W * CANVAS_H;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 600000;

    // One output word as the decoder should produce it
    typedef struct {
        logic [sprd_pkg::PIX_X_W-1:0] x;
        logic [sprd_pkg::PIX_Y_W-1:0] y;
        logic [7:0]                   pal;
        logic                         done;
        logic                         bad;
    } pixel_write_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [sprd_pkg::OUT_DATA_W-1:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;

    // Decoder state mirror
    bit header_pending = 1'b1;
    bit skip_pending   = 1'b0;
    int write_offset   = 0;

    pixel_write_t pixel_writes_q[$];
    int errors      = 0;
    int bytes_sent  = 0;
    int cycle_count = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;

    sprite_skip_run_decoder #(
        .CANVAS_WIDTH (CANVAS_W),
        .CANVAS_HEIGHT(CANVAS_H)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hard stop if the run hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, pixel_writes_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int draw_wait(int pct);
        if ($urandom_range(0, 99) < pct)
            return $urandom_range(1, 19);
        return 0;
    endfunction

    function automatic int sat_advance(int base, int inc);
        return (base + inc > CANVAS_CELLS) ? CANVAS_CELLS : base + inc;
    endfunction

    // Update the state mirror for one accepted byte; queue any pixel or done word
    task automatic decode_byte(logic [7:0] code, logic is_last);
        pixel_write_t w;
        begin
            w = '{x: '0, y: '0, pal: '0, done: 1'b0, bad: 1'b0};
            if (is_last) begin
                w.done = 1'b1;
                w.bad  = (code != sprd_pkg::CODE_END);
                pixel_writes_q.push_back(w);
                header_pending = 1'b1;
                skip_pending   = 1'b0;
                write_offset   = 0;
            end else if (header_pending) begin
                write_offset   = sat_advance(0, int'(code) * CANVAS_W);
                header_pending = 1'b0;
            end else if (skip_pending) begin
                write_offset = sat_advance(write_offset, int'(code));
                skip_pending = 1'b0;
            end else if (code == sprd_pkg::CODE_SKIP) begin
                skip_pending = 1'b1;
            end else if (code == sprd_pkg::CODE_CLEAR) begin
                write_offset = sat_advance(write_offset, 1);
            end else begin
                // Clip writes at or past the end of the canvas
                if (write_offset < CANVAS_CELLS) begin
                    w.x   = sprd_pkg::PIX_X_W'(write_offset % CANVAS_W);
                    w.y   = sprd_pkg::PIX_Y_W'(write_offset / CANVAS_W);
                    w.pal = code;
                    pixel_writes_q.push_back(w);
                end
                write_offset = sat_advance(write_offset, 1);
            end
        end
    endtask

    // Send one byte: idle for a drawn gap, then hold the word until accepted
    task automatic send_byte(logic [7:0] code, logic is_last);
        int gap;
        begin
            gap = draw_wait(src_idle_pct);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= code;
            s_tlast  <= is_last;
            do @(posedge aclk); while (!s_tready);
            decode_byte(code, is_last);
            bytes_sent++;
        end
    endtask

    // Drop valid and hold off until every expected word has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pixel_writes_q.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Output sink: stall a drawn number of cycles before each word
    initial begin
        int stall;
        forever begin
            stall = draw_wait(sink_idle_pct);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // Compare each accepted output word with the oldest expectation
    always @(posedge aclk) begin
        pixel_write_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pixel_writes_q.size() == 0) begin
                report_mismatch("output word with nothing expected, tdata", int'(m_tdata), 0);
            end else begin
                want = pixel_writes_q.pop_front();
                if (m_tdata[4:0] !== want.x)
                    report_mismatch("pixel_x", int'(m_tdata[4:0]), int'(want.x));
                if (m_tdata[10:5] !== want.y)
                    report_mismatch("pixel_y", int'(m_tdata[10:5]), int'(want.y));
                if (m_tdata[18:11] !== want.pal)
                    report_mismatch("palette_index", int'(m_tdata[18:11]), int'(want.pal));
                if (m_tdata[23:19] !== '0)
                    report_mismatch("tdata padding", int'(m_tdata[23:19]), 0);
                if (m_tlast !== want.done)
                    report_mismatch("frame_done", int'(m_tlast), int'(want.done));
                if (m_tuser[0] !== want.bad)
                    report_mismatch("bad_terminator", int'(m_tuser[0]), int'(want.bad));
            end
        end
    end

    // Hand-picked frames: control codes, clipping, saturation, odd terminators
    task automatic test_directed_cases();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        // Row 0: pixel, transparent, skip, 0xFF as a plain pixel, clean end
        send_byte(8'd0, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(sprd_pkg::CODE_CLEAR, 1'b0);
        send_byte(sprd_pkg::CODE_SKIP, 1'b0);
        send_byte(8'd5, 1'b0);
        send_byte(sprd_pkg::CODE_END, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(sprd_pkg::CODE_END, 1'b1);
        // Terminator in place of the header, not 0xFF
        send_byte(8'h00, 1'b1);
        // Last row, run past the canvas end and clip
        send_byte(8'd47, 1'b0);
        send_byte(sprd_pkg::CODE_SKIP, 1'b0);
        send_byte(8'd30, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hAB, 1'b1);
        // Header product saturates; pixel is clipped
        send_byte(8'd255, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(sprd_pkg::CODE_END, 1'b1);
        // Terminator arriving where a skip count is due
        send_byte(8'd48, 1'b0);
        send_byte(sprd_pkg::CODE_SKIP, 1'b0);
        send_byte(sprd_pkg::CODE_END, 1'b1);
        // A 0xFE header and a maximal skip saturate the offset
        send_byte(sprd_pkg::CODE_SKIP, 1'b0);
        send_byte(sprd_pkg::CODE_SKIP, 1'b0);
        send_byte(8'd255, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(sprd_pkg::CODE_SKIP, 1'b1);
        wait_for_results();
    endtask

    // Well-formed frames with random content, some cut short or badly ended
    task automatic send_random_frame();
        int body_len;
        int pick;
        logic [7:0] code;
        begin
            if ($urandom_range(0, 9) == 0)
                send_byte(8'($urandom_range(0, 255)), 1'b0);
            else
                send_byte(8'($urandom_range(0, CANVAS_H - 1)), 1'b0);
            body_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 120)
                                                   : $urandom_range(0, 40);
            for (int i = 0; i < body_len; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 15) begin
                    send_byte(sprd_pkg::CODE_CLEAR, 1'b0);
                end else if (pick < 30) begin
                    send_byte(sprd_pkg::CODE_SKIP, 1'b0);
                    if ($urandom_range(0, 4) == 0)
                        send_byte(8'($urandom_range(0, 255)), 1'b0);
                    else
                        send_byte(8'($urandom_range(0, 40)), 1'b0);
                end else if (pick < 32) begin
                    // Stray terminator mid-frame
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
                end else begin
                    code = 8'($urandom_range(0, 255));
                    if (code == sprd_pkg::CODE_CLEAR || code == sprd_pkg::CODE_SKIP)
                        code = sprd_pkg::CODE_END;
                    send_byte(code, 1'b0);
                end
            end
            if ($urandom_range(0, 9) == 0)
                send_byte(sprd_pkg::CODE_SKIP, 1'b0);
            if ($urandom_range(0, 4) == 0)
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            else
                send_byte(sprd_pkg::CODE_END, 1'b1);
        end
    endtask

    task automatic test_random_frames(int src_pct, int sink_pct, int n_bytes);
        int stop_at;
        begin
            src_idle_pct  = src_pct;
            sink_idle_pct = sink_pct;
            stop_at = bytes_sent + n_bytes;
            while (bytes_sent < stop_at) send_random_frame();
            wait_for_results();
        end
    endtask

    // Unstructured bytes with occasional terminators
    task automatic test_raw_bytes(int n_bytes);
        src_idle_pct  = 40;
        sink_idle_pct = 40;
        repeat (n_bytes)
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        wait_for_results();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_random_frames(0, 0, 350);
        test_random_frames(30, 30, 350);
        test_random_frames(100, 0, 350);
        test_random_frames(0, 100, 350);
        test_random_frames(50, 80, 350);
        test_raw_bytes(250);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
rtl/sprd_pkg.sv
rtl/sprd_in_stage.sv
rtl/sprd_core.sv
rtl/sprite_skip_run_decoder.sv
rtl/sprd_checker.sv
tb/tb.sv
